@@ rtl/sld_pkg.sv @@
`timescale 1ns / 1ps

package sld_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned DUTY_BITS_DEF   = 10;
	localparam int unsigned PHASE_STEPS_DEF = 256;

	// Fixed field widths of the channels.
	localparam int unsigned DUTY_W    = 10;
	localparam int unsigned MASK_W    = 8;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned TIMEOUT_W = 20;
	localparam int unsigned STATE_W   = 3;

	// Configuration port.
	localparam int unsigned PADDR_W      = 3;
	localparam int unsigned PDATA_W      = 32;
	localparam logic        REG_TIMEOUT  = 1'b0;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd1000;

	// Input command codes.
	localparam logic CMD_TELEMETRY = 1'b0;
	localparam logic CMD_TICK      = 1'b1;

	// Q30 fixed-point constants for the breathing table.
	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// Light states in priority order.
	typedef enum logic [STATE_W-1:0] {
		LS_INIT       = 3'd0,
		LS_DISCONNECT = 3'd1,
		LS_ESTOP      = 3'd2,
		LS_CAUTION    = 3'd3,
		LS_NORMAL     = 3'd4
	} light_state_t;

	// Buzzer square-wave phases for both buzzer periods.
	typedef struct packed {
		logic fast_odd;
		logic slow_odd;
	} buzz_phase_t;

	// One breathing table entry: sin^2 of the angle x (Q30) scaled to full_scale.
	// Only evaluated while the design elaborates.
	function automatic logic [DUTY_W-1:0] breath_entry(longint unsigned x,
		longint unsigned full_scale);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned sq;
		longint unsigned scaled;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int i = 1; i <= 8; i++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[i-1];
			if ((i % 2) == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		if (sum > Q30_ONE) begin
			sum = Q30_ONE;
		end
		sq = ((sum * sum) >> 30) + 64'd64;
		if (sq > Q30_ONE) begin
			sq = Q30_ONE;
		end
		scaled = (sq * full_scale) >> 30;
		return scaled[DUTY_W-1:0];
	endfunction

endpackage

@@ rtl/sld_in_if.sv @@
`timescale 1ns / 1ps

interface sld_in_if;
	import sld_pkg::*;

	logic                valid;
	logic                ready;
	logic                cmd;
	logic [MASK_W-1:0]   estop_src;
	logic [MASK_W-1:0]   caution_src;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, cmd, estop_src, caution_src, now_ms, input ready);
	modport sink (input valid, cmd, estop_src, caution_src, now_ms, output ready);
endinterface

@@ rtl/sld_out_if.sv @@
`timescale 1ns / 1ps

interface sld_out_if;
	import sld_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATE_W-1:0]  light_state;
	logic [DUTY_W-1:0]   red_duty;
	logic [DUTY_W-1:0]   yellow_duty;
	logic [DUTY_W-1:0]   green_duty;
	logic [DUTY_W-1:0]   buzzer_duty;

	modport source (output valid, light_state, red_duty, yellow_duty, green_duty,
		buzzer_duty, input ready);
	modport sink (input valid, light_state, red_duty, yellow_duty, green_duty,
		buzzer_duty, output ready);
endinterface

@@ rtl/sld_apb_regs.sv @@
`timescale 1ns / 1ps

module sld_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sld_pkg::PADDR_W-1:0]    paddr,
	input  logic [sld_pkg::PDATA_W-1:0]    pwdata,
	output logic [sld_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	output logic [sld_pkg::TIMEOUT_W-1:0]  timeout_ms
);
	import sld_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 hit_timeout;

	// Only one register; bit 2 of the address selects it.
	assign hit_timeout = (paddr[2] == REG_TIMEOUT);
	assign pready      = 1'b1;

	// The timeout register is written in the access phase of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && hit_timeout) begin
			timeout_q <= pwdata[TIMEOUT_W-1:0];
		end
	end

	// Read data; unmapped addresses read as zero.
	always_comb begin
		prdata = '0;
		if (hit_timeout) begin
			prdata = PDATA_W'(timeout_q);
		end
	end

	assign timeout_ms = timeout_q;
endmodule

@@ rtl/sld_phase.sv @@
`timescale 1ns / 1ps

module sld_phase #(
	parameter int unsigned PHASE_STEPS = sld_pkg::PHASE_STEPS_DEF
) (
	input  logic [sld_pkg::TIME_W-1:0]     now_ms,
	input  logic                           fast,
	output logic [$clog2(PHASE_STEPS)-1:0] idx,
	output sld_pkg::buzz_phase_t           buzz
);
	import sld_pkg::*;

	localparam int unsigned IW = $clog2(PHASE_STEPS);

	// Index = floor(x * PHASE_STEPS / 2000) through an exact reciprocal,
	// with x below 2000.
	localparam int unsigned     NUM_W   = $clog2(2000 * PHASE_STEPS);
	localparam int unsigned     SHIFT   = NUM_W + 11;
	localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + 64'd1999) / 64'd2000;
	localparam longint unsigned RECIP_P = RECIP * PHASE_STEPS;
	localparam int unsigned     PROD_W  = SHIFT + IW;

	logic [27:0]       n;
	logic [12:0]       fold1;
	logic [7:0]        fold2;
	logic [6:0]        r125;
	logic [10:0]       r2000;
	logic [1:0]        q500;
	logic [8:0]        r500;
	logic [10:0]       x;
	logic [PROD_W-1:0] prod;
	logic [IW-1:0]     idx_raw;

	// now mod 2000 = (now/16 mod 125) * 16 + now mod 16.
	// 128 is 3 mod 125, so 7-bit chunks fold with weights 1, 3, 9, 27.
	assign n     = now_ms[31:4];
	assign fold1 = 13'(n[6:0]) + 13'(n[13:7]) * 13'd3 + 13'(n[20:14]) * 13'd9
		+ 13'(n[27:21]) * 13'd27;
	assign fold2 = 8'(fold1[6:0]) + 8'(fold1[12:7]) * 8'd3;
	assign r125  = (fold2 >= 8'd125) ? 7'(fold2 - 8'd125) : fold2[6:0];
	assign r2000 = {r125, now_ms[3:0]};

	// Split the 2000 ms phase into 500 ms quarters.
	always_comb begin
		if (r2000 >= 11'd1500) begin
			q500 = 2'd3;
			r500 = 9'(r2000 - 11'd1500);
		end else if (r2000 >= 11'd1000) begin
			q500 = 2'd2;
			r500 = 9'(r2000 - 11'd1000);
		end else if (r2000 >= 11'd500) begin
			q500 = 2'd1;
			r500 = 9'(r2000 - 11'd500);
		end else begin
			q500 = 2'd0;
			r500 = r2000[8:0];
		end
	end

	// Buzzer halves: 250 ms for the fast wave, 500 ms for the slow one.
	assign buzz.fast_odd = (r500 >= 9'd250);
	assign buzz.slow_odd = q500[0];

	// The fast period is a quarter of the slow one, so scale its phase by four.
	assign x       = fast ? {r500, 2'b00} : r2000;
	assign prod    = PROD_W'(x) * PROD_W'(RECIP_P);
	assign idx_raw = prod[SHIFT +: IW];
	assign idx     = (idx_raw > IW'(PHASE_STEPS - 1)) ? IW'(PHASE_STEPS - 1) : idx_raw;
endmodule

@@ rtl/sld_breath_rom.sv @@
`timescale 1ns / 1ps

module sld_breath_rom #(
	parameter int unsigned DUTY_BITS   = sld_pkg::DUTY_BITS_DEF,
	parameter int unsigned PHASE_STEPS = sld_pkg::PHASE_STEPS_DEF
) (
	input  logic [$clog2(PHASE_STEPS)-1:0] idx,
	output logic [sld_pkg::DUTY_W-1:0]     duty
);
	import sld_pkg::*;

	localparam longint unsigned FULL_SCALE = (64'd1 << DUTY_BITS) - 64'd1;

	logic [DUTY_W-1:0] rom [PHASE_STEPS];

	// Raised-cosine table, worked out at elaboration.
	for (genvar k = 0; k < PHASE_STEPS; k++) begin : g_entry
		localparam longint unsigned M = (k <= PHASE_STEPS / 2) ?
			longint'(k) : longint'(PHASE_STEPS - k);
		localparam longint unsigned X = (PI_Q30 * M) / PHASE_STEPS;
		assign rom[k] = breath_entry(X, FULL_SCALE);
	end

	// Table lookup; the index never exceeds the last entry.
	always_comb begin
		duty = '0;
		if (32'(idx) < PHASE_STEPS) begin
			duty = rom[idx];
		end
	end
endmodule

@@ rtl/stack_light_status_driver.sv @@
`timescale 1ns / 1ps
// Stack light status driver.
// The item channel carries two kinds of transfer. A telemetry transfer (cmd 0)
// stores the e-stop and caution masks and its timestamp and yields no result.
// A tick transfer (cmd 1) yields one result on the result channel: the light
// state (init, disconnect, e-stop, caution, normal, in that priority) and the
// red, yellow, green and buzzer PWM duties for the given now_ms.
// The APB port holds the telemetry timeout in ms at address 0 (reset 1000).
// An item transfer is captured in the input register stage and its result in the
// result register, with the state decision, constant-divisor phase logic and
// table lookup between the two.
// Throughput is one item per cycle while results are taken; an item is
// accepted whenever the input stage is empty or can move into or past the
// result register. When the receiver stalls, the result holds and the input
// stage fills, after which item ready drops until the result is taken.
// Reset clears the stored telemetry (init state shown) and both stages and sets
// the timeout register to 1000; no clearing pass is needed.

module stack_light_status_driver #(
	parameter int unsigned DUTY_BITS   = sld_pkg::DUTY_BITS_DEF,
	parameter int unsigned PHASE_STEPS = sld_pkg::PHASE_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sld_in_if.sink                       item,
	sld_out_if.source                    result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sld_pkg::PADDR_W-1:0]  paddr,
	input  logic [sld_pkg::PDATA_W-1:0]  pwdata,
	output logic [sld_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import sld_pkg::*;

	localparam int unsigned       IW         = $clog2(PHASE_STEPS);
	localparam logic [DUTY_W-1:0] DUTY_FIELD = DUTY_W'((64'd1 << DUTY_BITS) - 64'd1);

	logic [TIMEOUT_W-1:0] timeout_ms;

	// Input stage.
	logic              valid_s1;
	logic              cmd_s1;
	logic [MASK_W-1:0] estop_s1;
	logic [MASK_W-1:0] caution_s1;
	logic [TIME_W-1:0] now_s1;

	// Stored telemetry.
	logic              seen_q;
	logic [TIME_W-1:0] last_update_q;
	logic [MASK_W-1:0] estop_mask_q;
	logic [MASK_W-1:0] caution_mask_q;

	// Result register.
	logic              res_valid_q;
	logic [STATE_W-1:0] res_state_q;
	logic [DUTY_W-1:0] res_red_q;
	logic [DUTY_W-1:0] res_yellow_q;
	logic [DUTY_W-1:0] res_green_q;
	logic [DUTY_W-1:0] res_buzzer_q;

	logic              advance;
	logic [TIME_W-1:0] age;
	light_state_t      state;
	logic              fast;
	logic [IW-1:0]     idx;
	buzz_phase_t       buzz;
	logic [DUTY_W-1:0] breath;
	logic [DUTY_W-1:0] red;
	logic [DUTY_W-1:0] yellow;
	logic [DUTY_W-1:0] green;
	logic [DUTY_W-1:0] buzzer;

	sld_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.timeout_ms (timeout_ms)
	);

	// The input stage moves on whenever the result register is free or being taken.
	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1     <= item.cmd;
			estop_s1   <= item.estop_src;
			caution_s1 <= item.caution_src;
			now_s1     <= item.now_ms;
		end
	end

	// A telemetry item updates the stored state as it leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q         <= 1'b0;
			last_update_q  <= '0;
			estop_mask_q   <= '0;
			caution_mask_q <= '0;
		end else if (valid_s1 && advance && (cmd_s1 == CMD_TELEMETRY)) begin
			seen_q         <= 1'b1;
			last_update_q  <= now_s1;
			estop_mask_q   <= estop_s1;
			caution_mask_q <= caution_s1;
		end
	end

	// Light state by priority; the age wraps modulo 2^32.
	assign age = now_s1 - last_update_q;

	always_comb begin
		if (!seen_q) begin
			state = LS_INIT;
		end else if (age > TIME_W'(timeout_ms)) begin
			state = LS_DISCONNECT;
		end else if (estop_mask_q != '0) begin
			state = LS_ESTOP;
		end else if (caution_mask_q != '0) begin
			state = LS_CAUTION;
		end else begin
			state = LS_NORMAL;
		end
	end

	assign fast = (state == LS_ESTOP);

	sld_phase #(
		.PHASE_STEPS (PHASE_STEPS)
	) u_phase (
		.now_ms (now_s1),
		.fast   (fast),
		.idx    (idx),
		.buzz   (buzz)
	);

	sld_breath_rom #(
		.DUTY_BITS   (DUTY_BITS),
		.PHASE_STEPS (PHASE_STEPS)
	) u_rom (
		.idx  (idx),
		.duty (breath)
	);

	// Lamp and buzzer duties for the chosen state.
	always_comb begin
		red    = '0;
		yellow = '0;
		green  = '0;
		buzzer = '0;
		case (state)
			LS_NORMAL: begin
				green = DUTY_FIELD;
			end
			LS_CAUTION: begin
				yellow = DUTY_FIELD;
			end
			LS_ESTOP: begin
				red    = breath;
				buzzer = buzz.fast_odd ? DUTY_FIELD : '0;
			end
			LS_DISCONNECT: begin
				red    = breath;
				buzzer = buzz.slow_odd ? DUTY_FIELD : '0;
			end
			default: begin
				red = breath;
			end
		endcase
	end

	// Result register: loaded by each tick that leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && (cmd_s1 == CMD_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && (cmd_s1 == CMD_TICK)) begin
			res_state_q  <= state;
			res_red_q    <= red;
			res_yellow_q <= yellow;
			res_green_q  <= green;
			res_buzzer_q <= buzzer;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.light_state = res_state_q;
	assign result.red_duty    = res_red_q;
	assign result.yellow_duty = res_yellow_q;
	assign result.green_duty  = res_green_q;
	assign result.buzzer_duty = res_buzzer_q;
endmodule

@@ rtl/sld_checker.sv @@
`timescale 1ns / 1ps

module sld_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         item_cmd,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [sld_pkg::STATE_W-1:0]  light_state,
	input logic [sld_pkg::DUTY_W-1:0]   red_duty,
	input logic [sld_pkg::DUTY_W-1:0]   yellow_duty,
	input logic [sld_pkg::DUTY_W-1:0]   buzzer_duty
);
	import sld_pkg::*;

	// A pending result is held until its transfer.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped before transfer");

	// With the result register empty, the block takes an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item ready low with empty result register");

	// A new result follows a tick transfer that passed through the input stage.
	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready && (item_cmd == CMD_TICK), 2))
		else $error("result without a preceding tick");

	// Normal state lights green only.
	a_normal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (light_state == LS_NORMAL) |->
			(red_duty == '0) && (yellow_duty == '0) && (buzzer_duty == '0))
		else $error("normal state drives red, yellow or buzzer");
endmodule

bind stack_light_status_driver sld_checker u_sld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_cmd     (item.cmd),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.light_state  (result.light_state),
	.red_duty     (result.red_duty),
	.yellow_duty  (result.yellow_duty),
	.buzzer_duty  (result.buzzer_duty)
);
